// ----- rtl/lgld_pkg.sv -----
package lgld_pkg;

    localparam int ALPHABET    = 26;
    localparam int MAX_NAMES   = 4096;
    localparam int LETTER_W    = $clog2(ALPHABET);
    localparam int NAME_AW     = $clog2(MAX_NAMES);
    localparam int OP_W        = 2;
    localparam int NAME_IN_W   = 12;
    localparam int LETTER_IN_W = 5;
    localparam int ANSWER_W    = 6;
    localparam int DIST_W      = 5;

    localparam logic [DIST_W-1:0]   DIST_INF      = 5'd31;
    localparam logic [DIST_W-1:0]   DIST_ONE      = 5'd1;
    localparam logic [ANSWER_W-1:0] SHARED_ANSWER = 6'd2;
    localparam logic [ANSWER_W-1:0] CHAIN_EXTRA   = 6'd2;
    localparam logic [ANSWER_W-1:0] ANSWER_NONE   = 6'h3F;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef logic [DIST_W-1:0]   dist_t;
    typedef dist_t [ALPHABET-1:0] row_t;
    typedef logic [ALPHABET-1:0] letter_set_t;

    typedef enum logic [1:0] {
        ROW_RELAX,
        ROW_LINK,
        ROW_SCAN
    } row_op_t;

    typedef struct packed {
        row_op_t             op;
        logic [LETTER_W-1:0] sel;
        logic                self_row;
        logic                set_row;
    } row_ctrl_t;

endpackage

// ----- rtl/lgld_dist_mem.sv -----
module lgld_dist_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr,
    input  logic [lgld_pkg::LETTER_W-1:0] rd_addr,
    output lgld_pkg::row_t                rd_data,
    input  logic                          wr_en,
    input  logic [lgld_pkg::LETTER_W-1:0] wr_addr,
    input  lgld_pkg::row_t                wr_data
);

    lgld_pkg::row_t                    mem [lgld_pkg::ALPHABET];
    logic [lgld_pkg::ALPHABET-1:0]     valid_reg;
    lgld_pkg::row_t                    rd_data_reg;
    logic                              rd_valid_reg;

    // rows never written since clear read as unreachable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : {lgld_pkg::ALPHABET{lgld_pkg::DIST_INF}};

endmodule

// ----- rtl/lgld_name_mem.sv -----
module lgld_name_mem (
    input  logic                         clk,
    input  logic [lgld_pkg::NAME_AW-1:0] rd_addr,
    output lgld_pkg::letter_set_t        rd_data,
    input  logic                         wr_en,
    input  logic [lgld_pkg::NAME_AW-1:0] wr_addr,
    input  lgld_pkg::letter_set_t        wr_data
);

    lgld_pkg::letter_set_t mem [lgld_pkg::MAX_NAMES];
    lgld_pkg::letter_set_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lgld_row_unit.sv -----
module lgld_row_unit (
    input  lgld_pkg::row_ctrl_t   ctrl,
    input  lgld_pkg::row_t        row_in,
    input  lgld_pkg::row_t        aux,
    input  lgld_pkg::letter_set_t mask,
    output lgld_pkg::row_t        row_out
);

    lgld_pkg::dist_t pivot_elem;

    assign pivot_elem = row_in[ctrl.sel];

    for (genvar j = 0; j < lgld_pkg::ALPHABET; j++)
    begin : g_lane
        logic [lgld_pkg::DIST_W:0] sum;
        lgld_pkg::dist_t           via;
        logic                      is_sel;
        lgld_pkg::dist_t           lane_out;

        // saturating add of the path through the pivot letter
        assign sum    = {1'b0, pivot_elem} + {1'b0, aux[j]};
        assign via    = (sum >= {1'b0, lgld_pkg::DIST_INF}) ? lgld_pkg::DIST_INF
                                                            : sum[lgld_pkg::DIST_W-1:0];
        assign is_sel = (ctrl.sel == lgld_pkg::LETTER_W'(j));

        assign row_out[j] = lane_out;

        always_comb
        begin
            case (ctrl.op)
                lgld_pkg::ROW_RELAX:
                begin
                    lane_out = (via < row_in[j]) ? via : row_in[j];
                end
                lgld_pkg::ROW_LINK:
                begin
                    if (ctrl.self_row && (mask[j] || is_sel))
                    begin
                        lane_out = lgld_pkg::DIST_ONE;
                    end
                    else if (ctrl.set_row && is_sel)
                    begin
                        lane_out = lgld_pkg::DIST_ONE;
                    end
                    else
                    begin
                        lane_out = row_in[j];
                    end
                end
                lgld_pkg::ROW_SCAN:
                begin
                    // lane-wise running minimum over rows of the first name
                    if (ctrl.set_row && mask[j] && (row_in[j] < aux[j]))
                    begin
                        lane_out = row_in[j];
                    end
                    else
                    begin
                        lane_out = aux[j];
                    end
                end
                default:
                begin
                    lane_out = row_in[j];
                end
            endcase
        end
    end

endmodule

// ----- rtl/letter_graph_link_distance_top.sv -----
// channel   ports                                                transaction
// command   start, busy, op, name_index, letter, other_name      start high while busy low
// result    done, answer                                         done high for one cycle
//
// add: one read and one write of a distance row per letter
// query: row scan then lane reduction, or an early answer on a shared letter; the first
// query after an add first runs a closure pass with every letter as pivot
// clear and reset run a pass over all MAX_NAMES entries of the name memory with busy high
// the receiver cannot stall: every result is taken in the cycle done is high
module letter_graph_link_distance_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lgld_pkg::OP_W-1:0]        op,
    input  logic [lgld_pkg::NAME_IN_W-1:0]   name_index,
    input  logic [lgld_pkg::LETTER_IN_W-1:0] letter,
    input  logic [lgld_pkg::NAME_IN_W-1:0]   other_name,
    output logic                             done,
    output logic signed [lgld_pkg::ANSWER_W-1:0] answer
);

    localparam logic [lgld_pkg::LETTER_W-1:0] LETTER_LAST =
        lgld_pkg::LETTER_W'(lgld_pkg::ALPHABET - 1);
    localparam logic [lgld_pkg::NAME_AW-1:0] NAME_LAST =
        lgld_pkg::NAME_AW'(lgld_pkg::MAX_NAMES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_LINK_RD,
        S_LINK_WR,
        S_Q_RDA,
        S_Q_RDB,
        S_PIV_RD,
        S_PIV_LD,
        S_REL_RD,
        S_REL_WR,
        S_Q_CHECK,
        S_SCAN_RD,
        S_SCAN_AC,
        S_REDUCE
    } state_t;

    state_t                          state_reg, state_next;
    logic [lgld_pkg::NAME_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [lgld_pkg::LETTER_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [lgld_pkg::LETTER_W-1:0]   k_reg, k_next;
    logic                            stale_reg, stale_next;
    logic                            done_reg, done_next;
    logic [lgld_pkg::ANSWER_W-1:0]   answer_reg, answer_next;
    logic [lgld_pkg::NAME_AW-1:0]    na_reg, na_next;
    logic [lgld_pkg::NAME_AW-1:0]    nb_reg, nb_next;
    logic                            na_ok_reg, na_ok_next;
    logic                            nb_ok_reg, nb_ok_next;
    logic [lgld_pkg::LETTER_W-1:0]   letter_reg, letter_next;
    lgld_pkg::letter_set_t           set_reg, set_next;
    lgld_pkg::letter_set_t           sb_reg, sb_next;
    lgld_pkg::row_t                  pivot_reg, pivot_next;
    lgld_pkg::row_t                  acc_reg, acc_next;
    lgld_pkg::dist_t                 best_reg, best_next;

    logic                            na_in_range;
    logic                            nb_in_range;
    logic                            letter_in_range;
    lgld_pkg::dist_t                 cand;

    logic [lgld_pkg::NAME_AW-1:0]    name_rd_addr;
    lgld_pkg::letter_set_t           name_rd_data;
    logic                            name_wr_en;
    logic [lgld_pkg::NAME_AW-1:0]    name_wr_addr;
    lgld_pkg::letter_set_t           name_wr_data;

    logic                            dist_clr;
    logic [lgld_pkg::LETTER_W-1:0]   dist_rd_addr;
    lgld_pkg::row_t                  dist_rd_data;
    logic                            dist_wr_en;

    lgld_pkg::row_ctrl_t             row_ctrl;
    lgld_pkg::row_t                  row_aux;
    lgld_pkg::letter_set_t           row_mask;
    lgld_pkg::row_t                  row_out;

    lgld_name_mem u_name_mem (
        .clk     (clk),
        .rd_addr (name_rd_addr),
        .rd_data (name_rd_data),
        .wr_en   (name_wr_en),
        .wr_addr (name_wr_addr),
        .wr_data (name_wr_data)
    );

    lgld_dist_mem u_dist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (dist_clr),
        .rd_addr (dist_rd_addr),
        .rd_data (dist_rd_data),
        .wr_en   (dist_wr_en),
        .wr_addr (row_cnt_reg),
        .wr_data (row_out)
    );

    lgld_row_unit u_row_unit (
        .ctrl    (row_ctrl),
        .row_in  (dist_rd_data),
        .aux     (row_aux),
        .mask    (row_mask),
        .row_out (row_out)
    );

    assign na_in_range     = (32'(name_index) < 32'(lgld_pkg::MAX_NAMES));
    assign nb_in_range     = (32'(other_name) < 32'(lgld_pkg::MAX_NAMES));
    assign letter_in_range = (32'(letter) < 32'(lgld_pkg::ALPHABET));

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign answer = $signed(answer_reg);

    assign name_rd_addr = (state_reg == S_IDLE) ? name_index[lgld_pkg::NAME_AW-1:0] : nb_reg;
    assign dist_rd_addr = (state_reg == S_PIV_RD) ? k_reg : row_cnt_reg;
    assign dist_clr     = (state_reg == S_IDLE) && start && (op == lgld_pkg::OP_CLEAR);
    assign dist_wr_en   = (state_reg == S_LINK_WR) || (state_reg == S_REL_WR);

    assign cand = (acc_reg[row_cnt_reg] < best_reg) ? acc_reg[row_cnt_reg] : best_reg;

    always_comb
    begin
        name_wr_en   = 1'b0;
        name_wr_addr = clr_cnt_reg;
        name_wr_data = '0;
        if (state_reg == S_CLEAR)
        begin
            name_wr_en = 1'b1;
        end
        else if (state_reg == S_ADD_RD)
        begin
            name_wr_en   = 1'b1;
            name_wr_addr = na_reg;
            name_wr_data = name_rd_data | (lgld_pkg::letter_set_t'(1) << letter_reg);
        end
    end

    always_comb
    begin
        row_ctrl.set_row  = set_reg[row_cnt_reg];
        row_ctrl.self_row = (row_cnt_reg == letter_reg);
        row_aux           = pivot_reg;
        row_mask          = set_reg;
        case (state_reg)
            S_LINK_WR:
            begin
                row_ctrl.op  = lgld_pkg::ROW_LINK;
                row_ctrl.sel = letter_reg;
            end
            S_SCAN_AC:
            begin
                row_ctrl.op  = lgld_pkg::ROW_SCAN;
                row_ctrl.sel = letter_reg;
                row_aux      = acc_reg;
                row_mask     = sb_reg;
            end
            default:
            begin
                row_ctrl.op  = lgld_pkg::ROW_RELAX;
                row_ctrl.sel = k_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        row_cnt_next = row_cnt_reg;
        k_next       = k_reg;
        stale_next   = stale_reg;
        done_next    = 1'b0;
        answer_next  = answer_reg;
        na_next      = na_reg;
        nb_next      = nb_reg;
        na_ok_next   = na_ok_reg;
        nb_ok_next   = nb_ok_reg;
        letter_next  = letter_reg;
        set_next     = set_reg;
        sb_next      = sb_reg;
        pivot_next   = pivot_reg;
        acc_next     = acc_reg;
        best_next    = best_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NAME_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    na_next     = name_index[lgld_pkg::NAME_AW-1:0];
                    nb_next     = other_name[lgld_pkg::NAME_AW-1:0];
                    na_ok_next  = na_in_range;
                    nb_ok_next  = nb_in_range;
                    letter_next = letter[lgld_pkg::LETTER_W-1:0];
                    case (op)
                        lgld_pkg::OP_ADD:
                        begin
                            if (na_in_range && letter_in_range)
                            begin
                                state_next = S_ADD_RD;
                            end
                        end
                        lgld_pkg::OP_QUERY:
                        begin
                            state_next = S_Q_RDA;
                        end
                        lgld_pkg::OP_CLEAR:
                        begin
                            stale_next   = 1'b0;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                set_next     = name_rd_data;
                row_cnt_next = '0;
                state_next   = S_LINK_RD;
            end
            S_LINK_RD:
            begin
                state_next = S_LINK_WR;
            end
            S_LINK_WR:
            begin
                if (row_cnt_reg == LETTER_LAST)
                begin
                    stale_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next   = S_LINK_RD;
                end
            end
            S_Q_RDA:
            begin
                set_next   = na_ok_reg ? name_rd_data : '0;
                state_next = S_Q_RDB;
            end
            S_Q_RDB:
            begin
                sb_next = nb_ok_reg ? name_rd_data : '0;
                if (stale_reg)
                begin
                    k_next     = '0;
                    state_next = S_PIV_RD;
                end
                else
                begin
                    state_next = S_Q_CHECK;
                end
            end
            S_PIV_RD:
            begin
                state_next = S_PIV_LD;
            end
            S_PIV_LD:
            begin
                pivot_next   = dist_rd_data;
                row_cnt_next = '0;
                state_next   = S_REL_RD;
            end
            S_REL_RD:
            begin
                state_next = S_REL_WR;
            end
            S_REL_WR:
            begin
                if (row_cnt_reg == LETTER_LAST)
                begin
                    if (k_reg == LETTER_LAST)
                    begin
                        stale_next = 1'b0;
                        state_next = S_Q_CHECK;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_PIV_RD;
                    end
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next   = S_REL_RD;
                end
            end
            S_Q_CHECK:
            begin
                if ((set_reg & sb_reg) != '0)
                begin
                    done_next   = 1'b1;
                    answer_next = lgld_pkg::SHARED_ANSWER;
                    state_next  = S_IDLE;
                end
                else
                begin
                    acc_next     = {lgld_pkg::ALPHABET{lgld_pkg::DIST_INF}};
                    row_cnt_next = '0;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_AC;
            end
            S_SCAN_AC:
            begin
                acc_next = row_out;
                if (row_cnt_reg == LETTER_LAST)
                begin
                    row_cnt_next = '0;
                    best_next    = lgld_pkg::DIST_INF;
                    state_next   = S_REDUCE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_REDUCE:
            begin
                best_next = cand;
                if (row_cnt_reg == LETTER_LAST)
                begin
                    row_cnt_next = '0;
                    done_next    = 1'b1;
                    if (cand >= lgld_pkg::DIST_INF)
                    begin
                        answer_next = lgld_pkg::ANSWER_NONE;
                    end
                    else
                    begin
                        answer_next = lgld_pkg::ANSWER_W'(cand) + lgld_pkg::CHAIN_EXTRA;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            row_cnt_reg <= '0;
            k_reg       <= '0;
            stale_reg   <= 1'b0;
            done_reg    <= 1'b0;
            answer_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            row_cnt_reg <= row_cnt_next;
            k_reg       <= k_next;
            stale_reg   <= stale_next;
            done_reg    <= done_next;
            answer_reg  <= answer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        na_ok_reg  <= na_ok_next;
        nb_ok_reg  <= nb_ok_next;
        letter_reg <= letter_next;
        set_reg    <= set_next;
        sb_reg     <= sb_next;
        pivot_reg  <= pivot_next;
        acc_reg    <= acc_next;
        best_reg   <= best_next;
    end

endmodule
